// ===== src/minifloat11_add_mult_unit_top_assert.svh =====
// Assertion macros for the minifloat add/multiply unit.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef MINIFLOAT11_ADD_MULT_UNIT_TOP_ASSERT_SVH
`define MINIFLOAT11_ADD_MULT_UNIT_TOP_ASSERT_SVH

// An antecedent implies a consequent; any delay is written into the consequent.
`define MF11_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("minifloat unit: check failed");

// A condition never holds out of reset.
`define MF11_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("minifloat unit: forbidden condition");

`endif

// ===== src/mf11_pkg.sv =====
// Shared constants for the 1-4-6 minifloat add/multiply unit.
// No dependencies.
package mf11_pkg;
  localparam int unsigned WordW  = 11;
  localparam int unsigned ExpW   = 4;
  localparam int unsigned FracW  = 6;
  localparam int unsigned SumW   = 22;
  localparam int unsigned EbW    = 7;
  localparam logic [ExpW-1:0] ExpInf = 4'd15;
  localparam logic [ExpW-1:0] ExpZero = 4'd0;
  localparam logic signed [EbW-1:0] Bias = 7'sd7;
  localparam logic signed [EbW-1:0] NormOfs = 7'sd20;
  localparam int unsigned Latency = 3;
endpackage

// ===== src/minifloat11_add_mult_unit_top.sv =====
// Pipelined 1-4-6 minifloat adder/multiplier (top level).
// Depends on mf11_pkg and minifloat11_add_mult_unit_top_assert.svh.
// A start beat passes the operate, normalize and round registers to out_valid.
// Throughput: one beat per cycle; busy is always low, the three
// register stages (operate, normalize, round) each take a new beat.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
`include "minifloat11_add_mult_unit_top_assert.svh"
module minifloat11_add_mult_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [10:0] in_operand_a,
  input  logic [10:0] in_operand_b,
  output logic        out_valid,
  output logic [10:0] out_result
);
  localparam int unsigned SW = mf11_pkg::SumW;
  localparam int unsigned EW = mf11_pkg::EbW;

  // ---------------- stage 1: decode, align, add or multiply
  logic        sa, sb, a_ge_b;
  logic [3:0]  ea, eb, el, es, dexp;
  logic [5:0]  fl, fs;
  logic [20:0] ml, ms;
  logic [13:0] prod;
  logic        spec_nxt, sgn_nxt;
  logic [10:0] specv_nxt, big, sml;
  logic [SW-1:0] v_nxt;
  logic signed [EW-1:0] eb_nxt;

  logic          vld1_r, spec1_r, sgn1_r;
  logic [10:0]   specv1_r;
  logic [SW-1:0] v1_r;
  logic signed [EW-1:0] eb1_r;

  always_comb begin
    sa = in_operand_a[10];
    sb = in_operand_b[10];
    ea = in_operand_a[9:6];
    eb = in_operand_b[9:6];
    a_ge_b = in_operand_a[9:0] >= in_operand_b[9:0];
    big = a_ge_b ? in_operand_a : in_operand_b;
    sml = a_ge_b ? in_operand_b : in_operand_a;
    el = big[9:6];
    es = sml[9:6];
    fl = big[5:0];
    fs = sml[5:0];
    dexp = el - es;
    ml = {1'b1, fl, 14'd0};
    ms = {1'b1, fs, 14'd0} >> dexp;
    prod = {1'b1, in_operand_a[5:0]} * {1'b1, in_operand_b[5:0]};
    spec_nxt = 1'b0;
    specv_nxt = '0;
    sgn_nxt = big[10];
    v_nxt = '0;
    eb_nxt = '0;
    if (in_func) begin
      sgn_nxt = sa ^ sb;
      v_nxt = {prod, 8'd0};
      eb_nxt = $signed({3'd0, ea}) + $signed({3'd0, eb}) - mf11_pkg::Bias;
      if (ea == mf11_pkg::ExpZero || ea == mf11_pkg::ExpInf) begin
        spec_nxt = 1'b1;
        specv_nxt = {sa ^ sb, ea, 6'd0};
      end else if (eb == mf11_pkg::ExpZero || eb == mf11_pkg::ExpInf) begin
        spec_nxt = 1'b1;
        specv_nxt = {sa ^ sb, eb, 6'd0};
      end
    end else begin
      v_nxt = (sa == sb) ? ({1'b0, ml} + {1'b0, ms}) : ({1'b0, ml} - {1'b0, ms});
      eb_nxt = $signed({3'd0, el});
      if (ea == mf11_pkg::ExpInf) begin
        spec_nxt = 1'b1;
        specv_nxt = {sa, mf11_pkg::ExpInf, 6'd0};
      end else if (eb == mf11_pkg::ExpInf) begin
        spec_nxt = 1'b1;
        specv_nxt = {sb, mf11_pkg::ExpInf, 6'd0};
      end else if (ea == mf11_pkg::ExpZero) begin
        spec_nxt = 1'b1;
        specv_nxt = (eb == mf11_pkg::ExpZero) ? {sb, 10'd0} : in_operand_b;
      end else if (eb == mf11_pkg::ExpZero) begin
        spec_nxt = 1'b1;
        specv_nxt = in_operand_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= start;
    end
    spec1_r  <= spec_nxt;
    specv1_r <= specv_nxt;
    sgn1_r   <= sgn_nxt;
    v1_r     <= v_nxt;
    eb1_r    <= eb_nxt;
  end

  // ---------------- stage 2: find the leading one and normalize
  logic [4:0]    lead;
  logic [SW-1:0] norm;
  logic          vld2_r, spec2_r, sgn2_r, guard2_r, sticky2_r;
  logic [10:0]   specv2_r;
  logic [6:0]    mant2_r;
  logic signed [EW-1:0] e2_r;

  always_comb begin
    lead = '0;
    for (int i = 0; i < SW; i++) begin
      if (v1_r[i]) lead = 5'(i);
    end
    norm = v1_r << (5'(SW - 1) - lead);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    // An exact cancellation is forced to +0 here.
    spec2_r   <= spec1_r | (v1_r == '0);
    specv2_r  <= spec1_r ? specv1_r : 11'd0;
    sgn2_r    <= sgn1_r;
    mant2_r   <= norm[SW-1 -: 7];
    guard2_r  <= norm[SW-8];
    sticky2_r <= |norm[SW-9:0];
    e2_r      <= eb1_r + $signed({2'd0, lead}) - mf11_pkg::NormOfs;
  end

  // ---------------- stage 3: round to nearest even and pack
  logic [7:0] q;
  logic signed [EW-1:0] ef;
  logic [10:0] res_nxt;
  logic        vld3_r;
  logic [10:0] res3_r;

  always_comb begin
    q = {1'b0, mant2_r} + {7'd0, guard2_r & (sticky2_r | mant2_r[0])};
    ef = q[7] ? e2_r + 7'sd1 : e2_r;
    if (spec2_r) begin
      res_nxt = specv2_r;
    end else if (ef <= 7'sd0) begin
      res_nxt = {sgn2_r, 10'd0};
    end else if (ef >= $signed({3'd0, mf11_pkg::ExpInf})) begin
      res_nxt = {sgn2_r, mf11_pkg::ExpInf, 6'd0};
    end else begin
      // A carry out of rounding leaves an all-zero fraction.
      res_nxt = {sgn2_r, ef[3:0], q[7] ? 6'd0 : q[5:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    res3_r <= res_nxt;
  end

  assign busy       = 1'b0;
  assign out_valid  = vld3_r;
  assign out_result = res3_r;

  `MF11_ASSERT_IMPLY(a_latency, start, ##3 out_valid)
  `MF11_ASSERT_NEVER(a_no_busy, busy)
  `MF11_ASSERT_IMPLY(a_special_frac, out_valid && (out_result[9:6] == mf11_pkg::ExpInf || out_result[9:6] == mf11_pkg::ExpZero), out_result[5:0] == 6'd0 || !$past(in_func, 3))
endmodule

// ===== tb/tb_top.sv =====
// Testbench for the 1-4-6 minifloat add/multiply unit: directed and random beats,
// with results checked against a behavioral predictor. Depends on mf11_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  localparam int NumRandom = 1700;
  localparam int CycleLimit = 200000;
  localparam bit OpAdd = 1'b0;
  localparam bit OpMul = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_func;
  logic [10:0] in_operand_a;
  logic [10:0] in_operand_b;
  logic        out_valid;
  logic [10:0] out_result;

  minifloat11_add_mult_unit_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_result(out_result)
  );

  // Rounds m to nearest even after dropping k low bits.
  function automatic logic [31:0] round_even(logic [31:0] m, int k);
    logic [31:0] q, rem, half;
    q = m >> k;
    rem = m & ((32'd1 << k) - 1);
    half = 32'd1 << (k - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return q;
  endfunction

  function automatic logic [10:0] pack_word(logic s, int e, logic [31:0] q);
    if (q >= 128) begin
      q = q >> 1;
      e++;
    end
    if (e <= 0) return {s, 10'd0};
    if (e >= 15) return {s, mf11_pkg::ExpInf, 6'd0};
    return {s, 4'(e), q[5:0]};
  endfunction

  function automatic logic [10:0] class_word(logic s, logic [3:0] e);
    return {s, (e == mf11_pkg::ExpInf) ? mf11_pkg::ExpInf : mf11_pkg::ExpZero, 6'd0};
  endfunction

  function automatic logic [10:0] mf_multiply(logic [10:0] a, logic [10:0] b);
    logic [3:0] ea, eb;
    logic s;
    logic [31:0] p, q;
    int e;
    ea = a[9:6];
    eb = b[9:6];
    s = a[10] ^ b[10];
    if (ea == mf11_pkg::ExpZero || ea == mf11_pkg::ExpInf) return class_word(s, ea);
    if (eb == mf11_pkg::ExpZero || eb == mf11_pkg::ExpInf) return class_word(s, eb);
    p = (32'd64 + a[5:0]) * (32'd64 + b[5:0]);
    e = int'(ea) + int'(eb) - 7;
    if (p >= 8192) begin
      q = round_even(p, 7);
      e++;
    end else begin
      q = round_even(p, 6);
    end
    return pack_word(s, e, q);
  endfunction

  function automatic logic [10:0] mf_add(logic [10:0] a, logic [10:0] b);
    logic [10:0] big, sml;
    logic [31:0] ml, ms, v, q;
    int p, e;
    if (a[9:6] == mf11_pkg::ExpInf) return class_word(a[10], mf11_pkg::ExpInf);
    if (b[9:6] == mf11_pkg::ExpInf) return class_word(b[10], mf11_pkg::ExpInf);
    if (a[9:6] == mf11_pkg::ExpZero) return (b[9:6] == mf11_pkg::ExpZero) ? {b[10], 10'd0} : b;
    if (b[9:6] == mf11_pkg::ExpZero) return a;
    if (a[9:0] >= b[9:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    ml = (32'd64 + big[5:0]) << 14;
    ms = ((32'd64 + sml[5:0]) << 14) >> (big[9:6] - sml[9:6]);
    v = (big[10] == sml[10]) ? ml + ms : ml - ms;
    if (v == 0) return 11'd0;
    p = 31;
    while (p > 0 && !v[p]) p--;
    e = int'(big[9:6]) + p - 20;
    q = (p > 6) ? round_even(v, p - 6) : v << (6 - p);
    return pack_word(big[10], e, q);
  endfunction

  class result_board;
    logic [10:0] pending_q[$];
    int mismatches;
    int checked;
    int orphans;

    function void note_beat(bit op, logic [10:0] a, logic [10:0] b);
      pending_q.push_back(op == OpMul ? mf_multiply(a, b) : mf_add(a, b));
    endfunction

    function void check_result(logic [10:0] got);
      logic [10:0] want;
      if (pending_q.size() == 0) begin
        orphans++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  result_board board = new();
  int cycles;
  int adds, mults;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) board.check_result(out_result);
    if (cycles > CycleLimit) begin
      $display("minifloat11_add_mult_unit_top regression: fail");
      $finish;
    end
  end

  // Drives one beat and holds it until it is accepted.
  task automatic send_beat(bit op, logic [10:0] a, logic [10:0] b);
    start <= 1'b1;
    in_func <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (busy);
    board.note_beat(op, a, b);
    if (op == OpMul) mults++; else adds++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [10:0] rand_word();
    logic [3:0] e;
    case ($urandom_range(0, 9))
      0: e = mf11_pkg::ExpZero;
      1: e = mf11_pkg::ExpInf;
      default: e = 4'($urandom_range(1, 14));
    endcase
    return {1'($urandom), e, 6'($urandom)};
  endfunction

  initial begin
    logic [10:0] a, b;
    int burst;
    bit drained;
    drained = 1'b0;
    rst_n = 0;
    start = 0;
    in_func = 0;
    in_operand_a = 0;
    in_operand_b = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: zeros, infinities, cancellation, rounding carry, overflow, underflow.
    send_beat(OpAdd, 11'h000, 11'h400);
    send_beat(OpAdd, 11'h400, 11'h400);
    send_beat(OpAdd, 11'h000, 11'h1E5);
    send_beat(OpAdd, 11'h5E5, 11'h400);
    send_beat(OpAdd, 11'h3C0, 11'h7C0);
    send_beat(OpAdd, 11'h1C0, 11'h7D5);
    send_beat(OpAdd, 11'h1E5, 11'h5E5);
    send_beat(OpAdd, 11'h1FF, 11'h07F);
    send_beat(OpAdd, 11'h3BF, 11'h3BF);
    send_beat(OpAdd, 11'h041, 11'h440);
    send_beat(OpAdd, 11'h1FF, 11'h5C1);
    send_beat(OpAdd, 11'h3BF, 11'h041);
    send_beat(OpMul, 11'h000, 11'h3C0);
    send_beat(OpMul, 11'h3C0, 11'h000);
    send_beat(OpMul, 11'h5E3, 11'h7C9);
    send_beat(OpMul, 11'h1C5, 11'h40A);
    send_beat(OpMul, 11'h3BF, 11'h3BF);
    send_beat(OpMul, 11'h040, 11'h040);
    send_beat(OpMul, 11'h1FF, 11'h1FF);
    send_beat(OpMul, 11'h1C1, 11'h5FF);
    send_beat(OpMul, 11'h7FF, 11'h7FF);
    idle_cycles(1);

    for (int i = 0; i < NumRandom; ) begin
      burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      for (int j = 0; j < burst && i < NumRandom; j++, i++) begin
        a = ($urandom_range(0, 15) == 0) ? 11'($urandom) : rand_word();
        b = ($urandom_range(0, 15) == 0) ? 11'($urandom) : rand_word();
        // Near-cancellation sums exercise the normalizer.
        if ($urandom_range(0, 7) == 0) b = {~a[10], a[9:6], 6'($urandom)};
        send_beat(1'($urandom), a, b);
      end
      // Halfway through, let the pipeline run dry before sending more.
      if (!drained && i >= NumRandom / 2) begin
        drained = 1'b1;
        start <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
    end
    start <= 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (mf11_pkg::Latency + 4) @(posedge clk);
    $display("Covered %0d adds and %0d multiplies; %0d results checked.",
             adds, mults, board.checked);
    if (board.mismatches == 0) begin
      $display("minifloat11_add_mult_unit_top regression: pass");
    end else begin
      $display("%0d mismatches, %0d unexpected results", board.mismatches, board.orphans);
      $display("minifloat11_add_mult_unit_top regression: fail");
    end
    $finish;
  end
endmodule
